@@ design/nearest_key_binary_search_macros.svh @@
// Assertion helpers for the nearest-key search block.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef NEAREST_KEY_BINARY_SEARCH_MACROS_SVH
`define NEAREST_KEY_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication.
`define NKS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NKS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/nks_pkg.sv @@
package nks_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam int KEY_W      = 31;
   localparam int IDX_W      = 10;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 48;  // entry_index + key_value, padded to bytes
   localparam int RSP_DATA_W = 16;  // nearest_index, padded to bytes

   // Item kinds carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

@@ design/nearest_key_binary_search.sv @@
// Nearest-key lookup table.
// Request channel (req_*): a write beat (tuser = 0) stores key_value into slot
// entry_index and gives no response; a query beat (tuser = 1) searches the
// first min(entry_count, depth) slots for key_value and gives one response beat.
// Response channel (rsp_*): index of the exact or nearest key, tuser flags an
// empty table (index then 0). Ties between neighbors go to the lower index,
// keys outside the table clamp to the first or last entry.
// csr_wr_en/csr_wr_data load entry_count; write it only while idle.
// Search steps, accept to response valid: each binary-search probe is a memory
// read, then a compare on the one shared subtractor; at most clog2(n+1) probes
// for n = min(entry_count, depth), then a step to close the search, the HI_CMP
// and LO_CMP neighbor compares when needed, and a step to load the response; an
// empty table goes straight to the load. req_tready is low while a query runs and
// returns the cycle after the response loads, so one query at a time; writes are
// taken back to back while no query runs. Writes and probes share the key memory.
// The response sits in an output register: a stalled receiver does not stop
// the next request from being taken, but a finished query waits in place until
// the output register frees up.
// Reset (synchronous, active high) clears entry_count to 0 and drops all
// valids. Key memory is not cleared; only written slots may be searched.
module nearest_key_binary_search
   import nks_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = {pad, key_value[30:0], entry_index[9:0]}; tuser = op
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   // response: tdata = {pad, nearest_index[9:0]}; tuser = table_empty
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   // entry_count register
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;  // slot address
   localparam int CW = $clog2(TABLE_DEPTH + 1);                        // count / bound

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_HI_CMP,
      ST_LO_CMP,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [COUNT_W-1:0] entry_count_ff;
   logic [CW-1:0]      lo_ff;
   logic [CW-1:0]      hi_p1_ff;       // upper bound, one past the last candidate
   logic [CW-1:0]      n_ff;
   logic [AW-1:0]      mid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic signed [KEY_W:0] above_ff;
   logic [AW-1:0]      res_idx_ff;
   logic               res_empty_ff;
   logic               rsp_valid_ff;
   logic [AW-1:0]      rsp_idx_ff;
   logic               rsp_empty_ff;

   logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]   mem_rd_ff;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;

   logic [IDX_W-1:0]   req_slot;
   logic [KEY_W-1:0]   req_key;
   logic               req_fire;
   logic               rsp_load;
   logic [CW-1:0]      n_sat;
   logic [CW:0]        mid_sum;
   logic [AW-1:0]      mid;
   logic [KEY_W-1:0]   sub_a;
   logic [KEY_W-1:0]   sub_b;
   logic signed [KEY_W:0] diff;

   assign req_slot = req_tdata[IDX_W-1:0];
   assign req_key  = req_tdata[IDX_W+KEY_W-1:IDX_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // finished query moves into the output register once it is free
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // entry_count saturates at the table depth
   assign n_sat = (32'(entry_count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                      : CW'(entry_count_ff);

   // floor((lo + hi) / 2) with hi = hi_p1 - 1; only used while lo < hi_p1
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_p1_ff} - (CW+1)'(1);
   assign mid     = AW'(mid_sum >> 1);

   // Shared subtractor: probe - key for probe compares and the upper neighbor,
   // key - probe for the lower neighbor.
   always_comb begin
      if (state_ff == ST_LO_CMP) begin
         sub_a = key_ff;
         sub_b = mem_rd_ff;
      end else begin
         sub_a = mem_rd_ff;
         sub_b = key_ff;
      end
      diff = $signed({1'b0, sub_a}) - $signed({1'b0, sub_b});
   end

   // Single-port memory address / write enable
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = mid;
      unique case (state_ff)
         ST_IDLE: begin
            mem_addr = AW'(req_slot);
            mem_we   = req_fire && (req_tuser == OP_WRITE) && (32'(req_slot) < TABLE_DEPTH);
         end
         ST_PROBE_RD: begin
            mem_addr = (lo_ff < hi_p1_ff) ? mid : AW'(lo_ff);
         end
         ST_HI_CMP: begin
            mem_addr = AW'(lo_ff - CW'(1));
         end
         default: begin
            mem_addr = mid;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= req_key;
      end
      mem_rd_ff <= key_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // Search sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_idx_ff   <= res_idx_ff;
            rsp_empty_ff <= res_empty_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_tuser == OP_QUERY)) begin
                  key_ff   <= req_key;
                  lo_ff    <= '0;
                  hi_p1_ff <= n_sat;
                  n_ff     <= n_sat;
                  if (n_sat == '0) begin
                     res_idx_ff   <= '0;
                     res_empty_ff <= 1'b1;
                     state_ff     <= ST_DONE;
                  end else begin
                     res_empty_ff <= 1'b0;
                     state_ff     <= ST_PROBE_RD;
                  end
               end
            end
            ST_PROBE_RD: begin
               if (lo_ff < hi_p1_ff) begin
                  mid_ff   <= mid;
                  state_ff <= ST_PROBE_CMP;
               end else if (lo_ff >= n_ff) begin
                  // above the last entry
                  res_idx_ff <= AW'(n_ff - CW'(1));
                  state_ff   <= ST_DONE;
               end else if (lo_ff == '0) begin
                  // below the first entry
                  res_idx_ff <= '0;
                  state_ff   <= ST_DONE;
               end else begin
                  state_ff <= ST_HI_CMP;  // read of slot lo issued
               end
            end
            ST_PROBE_CMP: begin
               if (diff == '0) begin
                  res_idx_ff <= mid_ff;
                  state_ff   <= ST_DONE;
               end else begin
                  if (diff < 0) begin
                     lo_ff <= CW'(mid_ff) + CW'(1);
                  end else begin
                     hi_p1_ff <= CW'(mid_ff);
                  end
                  state_ff <= ST_PROBE_RD;
               end
            end
            ST_HI_CMP: begin
               above_ff <= diff;       // keys[lo] - key; read of lo-1 issued
               state_ff <= ST_LO_CMP;
            end
            ST_LO_CMP: begin
               // tie goes to the lower slot
               res_idx_ff <= (diff <= above_ff) ? AW'(lo_ff - CW'(1)) : AW'(lo_ff);
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-IDX_W)'(0), IDX_W'(rsp_idx_ff)};
   assign rsp_tuser  = rsp_empty_ff;

endmodule

@@ design/nks_checker.sv @@
`include "nearest_key_binary_search_macros.svh"

module nks_checker
   import nks_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic                req_beat;
   logic                write_beat;
   logic                query_beat;
   logic                rsp_stall;
   logic [RSP_DATA_W:0] rsp_word;

   assign req_beat   = req_tvalid && req_tready;
   assign write_beat = req_beat && (req_tuser == OP_WRITE);
   assign query_beat = req_beat && (req_tuser == OP_QUERY);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tuser, rsp_tdata};

   // stalled response beat stays up and holds its data
   `NKS_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "rsp beat not held")

   // empty-table response carries index 0
   `NKS_ASSERT_IMP(a_empty_idx, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "nonzero empty index")

   // a write beat never produces a response
   `NKS_ASSERT_NXT(a_write_silent, write_beat && !rsp_tvalid, !rsp_tvalid, "rsp after write")

   // one query at a time: busy right after a query is taken
   `NKS_ASSERT_NXT(a_query_busy, query_beat, !req_tready, "ready while query runs")

endmodule

bind nearest_key_binary_search nks_checker u_nks_checker (.*);
